// ===== design/neh_pkg.sv =====
// Shared types, constants and round functions for the nonce edge hash block.
// Used by neh_sip_pipe, neh_node_pipe and nonce_edge_hash; depends on nothing.
package neh_pkg;

    localparam int HASH_W     = 64;
    localparam int NONCE_W    = 32;
    localparam int U_W        = 20;
    localparam int V_W        = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

    localparam logic [HASH_W-1:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [HASH_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [HASH_W-1:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [HASH_W-1:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [HASH_W-1:0] SIP_FINAL_XOR = 64'h00000000000000ff;
    localparam logic [7:0]        MSG_LEN_BYTE  = 8'd4;

    // Each SipHash round is split into two half rounds, one per stage.
    localparam int COMP_HALVES = 4;
    localparam int SIP_HALVES  = 12;

    // Hash bits consumed per stage by the modular reduction.
    localparam int DIGIT_W = 2;

    typedef struct packed {
        logic [HASH_W-1:0] v0;
        logic [HASH_W-1:0] v1;
        logic [HASH_W-1:0] v2;
        logic [HASH_W-1:0] v3;
    } sip_state_t;

    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash_value;
        logic [U_W-1:0]    u_node;
        logic [V_W-1:0]    v_node;
    } result_t;

    function automatic logic [HASH_W-1:0] rotl64(input logic [HASH_W-1:0] x,
                                                 input int unsigned b);
        return (x << b) | (x >> (HASH_W - b));
    endfunction

    function automatic logic [HASH_W-1:0] msg_block(input logic [NONCE_W-1:0] nonce);
        return {MSG_LEN_BYTE, {(HASH_W - NONCE_W - 8){1'b0}}, nonce};
    endfunction

    function automatic sip_state_t sip_half_a(input sip_state_t s);
        sip_state_t r;
        r = s;
        r.v0 = r.v0 + r.v1;
        r.v1 = rotl64(r.v1, 13) ^ r.v0;
        r.v0 = rotl64(r.v0, 32);
        r.v2 = r.v2 + r.v3;
        r.v3 = rotl64(r.v3, 16) ^ r.v2;
        return r;
    endfunction

    function automatic sip_state_t sip_half_b(input sip_state_t s);
        sip_state_t r;
        r = s;
        r.v0 = r.v0 + r.v3;
        r.v3 = rotl64(r.v3, 21) ^ r.v0;
        r.v2 = r.v2 + r.v1;
        r.v1 = rotl64(r.v1, 17) ^ r.v2;
        r.v2 = rotl64(r.v2, 32);
        return r;
    endfunction

endpackage

// ===== design/nonce_edge_hash.sv =====
// Top level of the nonce edge hash: key registers, hash and node pipelines, output skid.
// Depends on neh_pkg, neh_sip_pipe and neh_node_pipe.
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_nonce
//   m_        out        m_valid / m_ready   m_hash_value, m_u_node, m_v_node
//   cfg_      in         cfg_we              cfg_index, cfg_data
//
// One word is accepted per cycle while s_ready is high, and each result passes through 13
// hash stages (initialization plus twelve half rounds), 32 reduction stages of two
// hash bits each, and the output register.
// Reset clears all valid bits and sets both key words to zero.
// When the output stalls, one more word drains into a skid register, then s_ready
// drops and the whole pipeline holds in place until the skid empties.
module nonce_edge_hash #(
    parameter int SIZE_SHIFT = 20,
    parameter int SIZE_MULT  = 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [neh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [neh_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [neh_pkg::NONCE_W-1:0]       s_nonce,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [neh_pkg::HASH_W-1:0]        m_hash_value,
    output logic [neh_pkg::U_W-1:0]           m_u_node,
    output logic [neh_pkg::V_W-1:0]           m_v_node
);
    import neh_pkg::*;

    localparam logic [63:0] SIZE       = 64'(SIZE_MULT) << SIZE_SHIFT;
    localparam logic [63:0] PART_U     = (SIZE >> 1) + 64'd1;
    localparam logic [63:0] PART_V_RAW = (SIZE >> 1) - 64'd1;
    localparam logic [63:0] PART_V     = (PART_V_RAW == 64'd0) ? 64'd1 : PART_V_RAW;
    localparam int          REM_U_W    = $clog2(PART_U);
    localparam int          REM_V_W    = $clog2(PART_V);

    logic [HASH_W-1:0]   key_low_reg;
    logic [HASH_W-1:0]   key_high_reg;

    pipe_ctrl_t          sip_ctrl;
    pipe_ctrl_t          node_ctrl;
    logic                advance;
    logic [HASH_W-1:0]   sip_hash;
    logic                sip_valid;
    logic [HASH_W-1:0]   node_hash;
    logic [REM_U_W-1:0]  rem_u;
    logic [REM_V_W-1:0]  rem_v;
    logic                node_valid;
    logic                pipe_emit;
    result_t             pipe_result;
    logic [63:0]         u_sum;
    logic [63:0]         v_sum;

    result_t             out_reg;
    result_t             out_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    result_t             skid_reg;
    result_t             skid_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == REG_KEY_LOW) begin
                key_low_reg <= cfg_data;
            end else if (cfg_index == REG_KEY_HIGH) begin
                key_high_reg <= cfg_data;
            end
        end
    end

    assign advance         = !skid_valid_reg;
    assign s_ready         = advance;
    assign sip_ctrl.advance  = advance;
    assign sip_ctrl.valid    = s_valid;
    assign node_ctrl.advance = advance;
    assign node_ctrl.valid   = sip_valid;

    neh_sip_pipe u_sip (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl_in    (sip_ctrl),
        .nonce      (s_nonce),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .hash_out   (sip_hash),
        .hash_valid (sip_valid)
    );

    neh_node_pipe #(
        .PART_U  (PART_U),
        .PART_V  (PART_V),
        .REM_U_W (REM_U_W),
        .REM_V_W (REM_V_W)
    ) u_node (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl_in    (node_ctrl),
        .hash_in    (sip_hash),
        .hash_out   (node_hash),
        .rem_u      (rem_u),
        .rem_v      (rem_v),
        .node_valid (node_valid)
    );

    // Node numbers wrap to the field widths when the partitions are wide.
    assign u_sum = 64'(rem_u) + 64'd1;
    assign v_sum = 64'(rem_v) + PART_U + 64'd1;
    assign pipe_result.hash_value = node_hash;
    assign pipe_result.u_node     = u_sum[U_W-1:0];
    assign pipe_result.v_node     = v_sum[V_W-1:0];
    assign pipe_emit = node_valid && advance;

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = pipe_result;
                out_valid_next = pipe_emit;
            end
        end else if (pipe_emit) begin
            skid_next       = pipe_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hash_value = out_reg.hash_value;
    assign m_u_node     = out_reg.u_node;
    assign m_v_node     = out_reg.v_node;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a word while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid register filled without an output stall");

    a_rem_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        node_valid |-> ((64'(rem_u) < PART_U) && (64'(rem_v) < PART_V)))
        else $error("reduction produced a remainder outside its partition");

    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && node_valid && advance) |=> !s_ready)
        else $error("input still open after the skid register filled");
`endif

endmodule

// ===== design/neh_sip_pipe.sv =====
// SipHash-2-4 pipeline: one initialization stage and one stage per half round.
// Depends on neh_pkg for the state type, constants and round functions.
module neh_sip_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  neh_pkg::pipe_ctrl_t           ctrl_in,
    input  logic [neh_pkg::NONCE_W-1:0]   nonce,
    input  logic [neh_pkg::HASH_W-1:0]    key_low,
    input  logic [neh_pkg::HASH_W-1:0]    key_high,
    output logic [neh_pkg::HASH_W-1:0]    hash_out,
    output logic                          hash_valid
);
    import neh_pkg::*;

    sip_state_t           state_reg  [SIP_HALVES+1];
    sip_state_t           state_next [SIP_HALVES+1];
    logic [NONCE_W-1:0]   nonce_reg  [COMP_HALVES+1];
    logic [NONCE_W-1:0]   nonce_next [COMP_HALVES+1];
    logic [SIP_HALVES:0]  valid_reg;
    logic [SIP_HALVES:0]  valid_next;

    always_comb begin
        sip_state_t s;
        state_next[0].v0 = SIP_C0 ^ key_low;
        state_next[0].v1 = SIP_C1 ^ key_high;
        state_next[0].v2 = SIP_C2 ^ key_low;
        state_next[0].v3 = SIP_C3 ^ key_high ^ msg_block(nonce);
        for (int j = 1; j <= SIP_HALVES; j++) begin
            s = state_reg[j-1];
            if (j == COMP_HALVES + 1) begin
                // The message block leaves v0 and finalization starts in v2.
                s.v0 = s.v0 ^ msg_block(nonce_reg[COMP_HALVES]);
                s.v2 = s.v2 ^ SIP_FINAL_XOR;
            end
            if ((j % 2) == 1) begin
                state_next[j] = sip_half_a(s);
            end else begin
                state_next[j] = sip_half_b(s);
            end
        end
        nonce_next[0] = nonce;
        for (int k = 1; k <= COMP_HALVES; k++) begin
            nonce_next[k] = nonce_reg[k-1];
        end
        valid_next = {valid_reg[SIP_HALVES-1:0], ctrl_in.valid};
    end

    always_ff @(posedge aclk) begin
        if (ctrl_in.advance) begin
            for (int j = 0; j <= SIP_HALVES; j++) begin
                state_reg[j] <= state_next[j];
            end
            for (int k = 0; k <= COMP_HALVES; k++) begin
                nonce_reg[k] <= nonce_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl_in.advance) begin
            valid_reg <= valid_next;
        end
    end

    assign hash_out = state_reg[SIP_HALVES].v0 ^ state_reg[SIP_HALVES].v1
                    ^ state_reg[SIP_HALVES].v2 ^ state_reg[SIP_HALVES].v3;
    assign hash_valid = valid_reg[SIP_HALVES];

endmodule

// ===== design/neh_node_pipe.sv =====
// Pipelined reduction of the hash modulo both partition sizes, a few bits per stage.
// Depends on neh_pkg for the control type and the digit width.
module neh_node_pipe #(
    parameter logic [63:0] PART_U  = 64'd524289,
    parameter logic [63:0] PART_V  = 64'd524287,
    parameter int          REM_U_W = 20,
    parameter int          REM_V_W = 19
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  neh_pkg::pipe_ctrl_t          ctrl_in,
    input  logic [neh_pkg::HASH_W-1:0]   hash_in,
    output logic [neh_pkg::HASH_W-1:0]   hash_out,
    output logic [REM_U_W-1:0]           rem_u,
    output logic [REM_V_W-1:0]           rem_v,
    output logic                         node_valid
);
    import neh_pkg::*;

    localparam int STAGES = HASH_W / DIGIT_W;
    localparam logic [REM_U_W:0] MOD_U = PART_U[REM_U_W:0];
    localparam logic [REM_V_W:0] MOD_V = PART_V[REM_V_W:0];

    logic [HASH_W-1:0]   hash_reg   [STAGES];
    logic [HASH_W-1:0]   hash_next  [STAGES];
    logic [REM_U_W-1:0]  ru_reg     [STAGES];
    logic [REM_U_W-1:0]  ru_next    [STAGES];
    logic [REM_V_W-1:0]  rv_reg     [STAGES];
    logic [REM_V_W-1:0]  rv_next    [STAGES];
    logic [STAGES-1:0]   valid_reg;
    logic [STAGES-1:0]   valid_next;

    function automatic logic [REM_U_W-1:0] reduce_u(input logic [REM_U_W-1:0] r,
                                                     input logic [DIGIT_W-1:0] d);
        logic [REM_U_W:0]   t;
        logic [REM_U_W-1:0] acc;
        acc = r;
        for (int k = 0; k < DIGIT_W; k++) begin
            t = {acc, d[DIGIT_W-1-k]};
            if (t >= MOD_U) begin
                t = t - MOD_U;
            end
            acc = t[REM_U_W-1:0];
        end
        return acc;
    endfunction

    function automatic logic [REM_V_W-1:0] reduce_v(input logic [REM_V_W-1:0] r,
                                                     input logic [DIGIT_W-1:0] d);
        logic [REM_V_W:0]   t;
        logic [REM_V_W-1:0] acc;
        acc = r;
        for (int k = 0; k < DIGIT_W; k++) begin
            t = {acc, d[DIGIT_W-1-k]};
            if (t >= MOD_V) begin
                t = t - MOD_V;
            end
            acc = t[REM_V_W-1:0];
        end
        return acc;
    endfunction

    always_comb begin
        logic [HASH_W-1:0]  h;
        logic [REM_U_W-1:0] ru;
        logic [REM_V_W-1:0] rv;
        for (int i = 0; i < STAGES; i++) begin
            if (i == 0) begin
                h  = hash_in;
                ru = '0;
                rv = '0;
            end else begin
                h  = hash_reg[i-1];
                ru = ru_reg[i-1];
                rv = rv_reg[i-1];
            end
            hash_next[i] = h;
            ru_next[i]   = reduce_u(ru, h[HASH_W-1-i*DIGIT_W -: DIGIT_W]);
            rv_next[i]   = reduce_v(rv, h[HASH_W-1-i*DIGIT_W -: DIGIT_W]);
        end
        valid_next = {valid_reg[STAGES-2:0], ctrl_in.valid};
    end

    always_ff @(posedge aclk) begin
        if (ctrl_in.advance) begin
            for (int i = 0; i < STAGES; i++) begin
                hash_reg[i] <= hash_next[i];
                ru_reg[i]   <= ru_next[i];
                rv_reg[i]   <= rv_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl_in.advance) begin
            valid_reg <= valid_next;
        end
    end

    assign hash_out   = hash_reg[STAGES-1];
    assign rem_u      = ru_reg[STAGES-1];
    assign rem_v      = rv_reg[STAGES-1];
    assign node_valid = valid_reg[STAGES-1];

endmodule
